// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/rau_pkg.sv =====
// Types and constants of the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

   // Operation codes; the unused code yields an all-zero result.
   typedef enum logic [2:0] {
      OP_MUL    = 3'd0,
      OP_DIV    = 3'd1,
      OP_ADD    = 3'd2,
      OP_SUB    = 3'd3,
      OP_INC    = 3'd4,
      OP_DEC    = 3'd5,
      OP_CMP    = 3'd6,
      OP_UNUSED = 3'd7
   } op_type;

   // Compare result codes.
   localparam logic signed [1:0] CMP_GT = 2'sb01;
   localparam logic signed [1:0] CMP_EQ = 2'sb00;
   localparam logic signed [1:0] CMP_LT = 2'sb11;

   // Stream widths.
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 136;

   // Request field positions.
   localparam int REQ_OP_LSB   = 0;
   localparam int REQ_OP_MSB   = 2;
   localparam int REQ_AN_LSB   = 3;
   localparam int REQ_AN_MSB   = 34;
   localparam int REQ_AD_LSB   = 35;
   localparam int REQ_AD_MSB   = 66;
   localparam int REQ_BN_LSB   = 67;
   localparam int REQ_BN_MSB   = 98;
   localparam int REQ_BD_LSB   = 99;
   localparam int REQ_BD_MSB   = 130;

   // Response field positions.
   localparam int RSP_NUM_LSB  = 0;
   localparam int RSP_NUM_MSB  = 63;
   localparam int RSP_DEN_LSB  = 64;
   localparam int RSP_DEN_MSB  = 127;
   localparam int RSP_CMP_LSB  = 128;
   localparam int RSP_CMP_MSB  = 129;
   localparam int RSP_ERR_BIT  = 130;
   localparam int RSP_PAD_LSB  = 131;
   localparam int RSP_PAD_MSB  = 135;

   // Normalized operands, after the first stage.
   typedef struct packed {
      op_type             op;
      logic               err;
      logic signed [32:0] an;
      logic signed [32:0] ad;
      logic signed [32:0] bn;
      logic signed [32:0] bd;
   } norm_type;

   // Products and pass-through terms, after the second stage.
   typedef struct packed {
      op_type             op;
      logic               err;
      logic               eq_den;
      logic signed [63:0] m0;
      logic signed [63:0] m1;
      logic signed [63:0] m2;
      logic signed [32:0] an;
      logic signed [32:0] ad;
      logic signed [32:0] bn;
   } prod_type;

endpackage

`default_nettype wire

// ===== src/rational_arithmetic_unit_core.sv =====
// Top level of the rational arithmetic unit: three-stage pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Fraction operator on a = a_num/a_den and b = b_num/b_den: multiply, divide,
// add, subtract, increment a, decrement a, compare. Results are not reduced;
// a zero denominator of an operand in use (or a divide by a zero numerator)
// returns err with all other fields zero. The pipeline takes one transaction
// per cycle while the output side keeps up, through registered stages:
// stage one normalizes signs and flags errors, stage two runs three 33x33
// signed multipliers, stage three forms the result fraction or comparison
// into the output register. Each stage holds under back-pressure and fills
// bubbles independently, so a stalled result does not block new input while
// an earlier stage is empty.
module rational_arithmetic_unit_core
   import rau_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // req_tdata, low bit up: op[3], a_num[32], a_den[32], b_num[32], b_den[32], zero pad[5]
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata, low bit up: res_num[64], res_den[64], cmp[2], err[1], zero pad[5]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   logic       s1_valid_ff, s1_valid_in;
   logic       s2_valid_ff, s2_valid_in;
   logic       s3_valid_ff, s3_valid_in;
   logic       s1_ready, s2_ready, s3_ready;
   norm_type   s1_ff, s1_in;
   prod_type   s2_ff, s2_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Per-stage ready: a stage takes new data when empty or when it drains.
   assign s3_ready   = !s3_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   assign s1_valid_in = s1_ready ? req_tvalid  : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   // Stage one: unpack, make denominators positive, detect errors.
   always_comb begin
      logic signed [32:0] an_raw, ad_raw, bn_raw, bd_raw;
      logic               binary;
      op_type             op;
      op     = op_type'(req_tdata[REQ_OP_MSB:REQ_OP_LSB]);
      an_raw = 33'(signed'(req_tdata[REQ_AN_MSB:REQ_AN_LSB]));
      ad_raw = 33'(signed'(req_tdata[REQ_AD_MSB:REQ_AD_LSB]));
      bn_raw = 33'(signed'(req_tdata[REQ_BN_MSB:REQ_BN_LSB]));
      bd_raw = 33'(signed'(req_tdata[REQ_BD_MSB:REQ_BD_LSB]));
      binary = op inside {OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_CMP};
      s1_in.op = op;
      s1_in.an = ad_raw[32] ? -an_raw : an_raw;
      s1_in.ad = ad_raw[32] ? -ad_raw : ad_raw;
      s1_in.bn = bd_raw[32] ? -bn_raw : bn_raw;
      s1_in.bd = bd_raw[32] ? -bd_raw : bd_raw;
      s1_in.err = (op != OP_UNUSED)
                  && ((ad_raw == '0) || (binary && (bd_raw == '0))
                      || ((op == OP_DIV) && (bn_raw == '0)));
   end

   // Stage two: three cross products, operands steered by the operation.
   always_comb begin
      logic signed [32:0] x0, x1;
      logic signed [65:0] p0, p1, p2;
      x0 = (s1_ff.op == OP_MUL) ? s1_ff.bn : s1_ff.bd;
      x1 = (s1_ff.op == OP_MUL) ? s1_ff.bd : s1_ff.bn;
      p0 = s1_ff.an * x0;
      p1 = s1_ff.ad * x1;
      p2 = s1_ff.ad * s1_ff.bd;
      s2_in.op     = s1_ff.op;
      s2_in.err    = s1_ff.err;
      s2_in.eq_den = (s1_ff.ad == s1_ff.bd);
      s2_in.m0     = p0[63:0];
      s2_in.m1     = p1[63:0];
      s2_in.m2     = p2[63:0];
      s2_in.an     = s1_ff.an;
      s2_in.ad     = s1_ff.ad;
      s2_in.bn     = s1_ff.bn;
   end

   // Stage three: combine products into the final fraction or compare code.
   always_comb begin
      logic signed [63:0] an64, ad64, bn64;
      logic signed [63:0] num, den;
      logic signed [1:0]  cmp;
      an64 = 64'(s2_ff.an);
      ad64 = 64'(s2_ff.ad);
      bn64 = 64'(s2_ff.bn);
      num  = '0;
      den  = '0;
      cmp  = CMP_EQ;
      case (s2_ff.op)
         OP_MUL, OP_DIV: begin
            num = s2_ff.m0;
            den = s2_ff.m1;
         end
         OP_ADD: begin
            num = s2_ff.eq_den ? (an64 + bn64) : (s2_ff.m0 + s2_ff.m1);
            den = s2_ff.eq_den ? ad64 : s2_ff.m2;
         end
         OP_SUB: begin
            num = s2_ff.eq_den ? (an64 - bn64) : (s2_ff.m0 - s2_ff.m1);
            den = s2_ff.eq_den ? ad64 : s2_ff.m2;
         end
         OP_INC: begin
            num = an64 + ad64;
            den = ad64;
         end
         OP_DEC: begin
            num = an64 - ad64;
            den = ad64;
         end
         OP_CMP: begin
            if (s2_ff.m0 > s2_ff.m1) begin
               cmp = CMP_GT;
            end else if (s2_ff.m0 < s2_ff.m1) begin
               cmp = CMP_LT;
            end
         end
         default: begin
            num = '0;
         end
      endcase
      // Drop everything on error.
      if (s2_ff.err) begin
         num = '0;
         den = '0;
         cmp = CMP_EQ;
      end
      rsp_data_in = '0;
      rsp_data_in[RSP_NUM_MSB:RSP_NUM_LSB] = num;
      rsp_data_in[RSP_DEN_MSB:RSP_DEN_LSB] = den;
      rsp_data_in[RSP_CMP_MSB:RSP_CMP_LSB] = cmp;
      rsp_data_in[RSP_ERR_BIT]             = s2_ff.err;
   end

   // Advance valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Advance payload; hold each stage while it is stalled.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
      if (s3_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== src/rau_checker.sv =====
// Port-level checker of the rational arithmetic unit and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rau_checker
   import rau_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [REQ_TDATA_W-1:0] req_tdata,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [63:0] res_num, res_den;
   logic [1:0]  res_cmp;
   logic        res_err;
   logic [4:0]  req_pad;
   logic        req_fire, rsp_stall;
   logic        err_clean, cmp_alone;

   assign res_num = rsp_tdata[RSP_NUM_MSB:RSP_NUM_LSB];
   assign res_den = rsp_tdata[RSP_DEN_MSB:RSP_DEN_LSB];
   assign res_cmp = rsp_tdata[RSP_CMP_MSB:RSP_CMP_LSB];
   assign res_err = rsp_tdata[RSP_ERR_BIT];
   assign req_pad = req_tdata[REQ_TDATA_W-1:REQ_BD_MSB+1];

   assign req_fire  = req_tvalid && req_tready && (req_pad == req_pad);
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign err_clean = res_num == '0 && res_den == '0 && res_cmp == CMP_EQ
                      && rsp_tdata[RSP_PAD_MSB:RSP_PAD_LSB] == '0;
   assign cmp_alone = res_num == '0 && res_den == '0 && !res_err
                      && (res_cmp == CMP_GT || res_cmp == CMP_LT);

   // A stalled result holds.
   `RAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // An error result carries zeros everywhere else, and padding stays zero.
   `RAU_ASSERT_IMP(a_err_zero, clock, reset, rsp_tvalid && res_err, err_clean)

   // A compare verdict comes alone, never with a fraction or the unused code.
   `RAU_ASSERT_IMP(a_cmp_alone, clock, reset, rsp_tvalid && res_cmp != CMP_EQ, cmp_alone)

   // With the output draining, an accepted transaction surfaces as a valid result.
   `RAU_ASSERT_NEXT(a_latency, clock, reset, req_fire ##1 rsp_tready ##1 rsp_tready, rsp_tvalid)

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking stream testbench for the rational arithmetic unit core.
`timescale 1ns / 1ps

module tb;
   import rau_pkg::*;

   localparam int MOST_NEG       = 32'h8000_0000;
   localparam int MOST_POS       = 32'h7fff_ffff;
   localparam int RANDOM_OPS     = 950;
   localparam int IDLE_PCT       = 10;
   localparam int CALM_FIRST     = 400;
   localparam int CALM_LAST      = 600;
   localparam int DRAIN_CYCLES   = 20;
   localparam int CYCLE_LIMIT    = 200000;

   // One request, laid out as req_tdata from the low bit up (op lowest).
   typedef struct packed {
      logic signed [31:0] b_den;
      logic signed [31:0] b_num;
      logic signed [31:0] a_den;
      logic signed [31:0] a_num;
      logic [2:0]         op;
   } frac_req_type;

   // One result, laid out as rsp_tdata from the low bit up (res_num lowest).
   typedef struct packed {
      logic               err;
      logic signed [1:0]  cmp;
      logic [63:0]        res_den;
      logic [63:0]        res_num;
   } frac_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   frac_req_type pending_ops[$];
   frac_rsp_type awaited_results[$];
   logic      req_fire = 1'b0;
   int        req_count = 0;
   int        rsp_count = 0;
   int        fail_count = 0;
   int        cycle_count = 0;
   int        total_ops;

   rational_arithmetic_unit_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Compute the expected result of one fraction operation.
   function automatic frac_rsp_type compute_fraction_result(frac_req_type r);
      longint       an, ad, bn, bd, p, q;
      logic         two_operand;
      frac_rsp_type y;
      y  = '0;
      an = {{32{r.a_num[31]}}, r.a_num};
      ad = {{32{r.a_den[31]}}, r.a_den};
      bn = {{32{r.b_num[31]}}, r.b_num};
      bd = {{32{r.b_den[31]}}, r.b_den};
      two_operand = (r.op <= OP_SUB) || (r.op == OP_CMP);
      if (r.op == OP_UNUSED) begin
         return y;
      end
      if (ad == 0 || (two_operand && bd == 0)) begin
         y.err = 1'b1;
         return y;
      end
      // Force positive denominators.
      if (ad < 0) begin
         ad = -ad;
         an = -an;
      end
      if (two_operand && bd < 0) begin
         bd = -bd;
         bn = -bn;
      end
      case (r.op)
         OP_MUL: begin
            y.res_num = an * bn;
            y.res_den = ad * bd;
         end
         OP_DIV: begin
            if (bn == 0) begin
               y.err = 1'b1;
            end else begin
               y.res_num = an * bd;
               y.res_den = ad * bn;
            end
         end
         OP_ADD, OP_SUB: begin
            if (ad == bd) begin
               y.res_num = (r.op == OP_ADD) ? an + bn : an - bn;
               y.res_den = ad;
            end else begin
               p = an * bd;
               q = bn * ad;
               y.res_num = (r.op == OP_ADD) ? p + q : p - q;
               y.res_den = ad * bd;
            end
         end
         OP_INC: begin
            y.res_num = an + ad;
            y.res_den = ad;
         end
         OP_DEC: begin
            y.res_num = an - ad;
            y.res_den = ad;
         end
         default: begin
            p = an * bd;
            q = bn * ad;
            y.cmp = (p > q) ? CMP_GT : ((p < q) ? CMP_LT : CMP_EQ);
         end
      endcase
      return y;
   endfunction

   // Mix small values, extremes and full-range words.
   function automatic logic [31:0] pick_operand();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = $urandom_range(0, 40) - 20;
         3: begin
            case ($urandom_range(0, 4))
               0: v = MOST_NEG;
               1: v = MOST_POS;
               2: v = 32'd0;
               3: v = 32'd1;
               default: v = 32'hffff_ffff;
            endcase
         end
         default: v = $urandom();
      endcase
      return v;
   endfunction

   task automatic add_op(input logic [2:0] op, input int an, input int ad,
                         input int bn, input int bd);
      frac_req_type r;
      r.op    = op;
      r.a_num = an;
      r.a_den = ad;
      r.b_num = bn;
      r.b_den = bd;
      pending_ops.push_back(r);
   endtask

   // Drive requests; advance only after the previous transaction was taken.
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fire)) begin
         if (pending_ops.size() != 0 &&
             ((req_count >= CALM_FIRST && req_count < CALM_LAST) ||
              $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {5'b0, pending_ops.pop_front()};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= (rsp_count >= CALM_FIRST && rsp_count < CALM_LAST) ||
                    ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Check each result transaction, then record the prediction for a new request.
   always @(posedge clock) begin
      frac_rsp_type got;
      frac_rsp_type want;
      if (!reset) begin
         req_fire <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[130:0];
            rsp_count <= rsp_count + 1;
            if (awaited_results.size() == 0) begin
               $error("result transaction with no request outstanding");
               fail_count = fail_count + 1;
            end else begin
               want = awaited_results.pop_front();
               if (got.res_num !== want.res_num) begin
                  $error("res_num: expected %0d, actual %0d",
                         $signed(want.res_num), $signed(got.res_num));
                  fail_count = fail_count + 1;
               end
               if (got.res_den !== want.res_den) begin
                  $error("res_den: expected %0d, actual %0d",
                         $signed(want.res_den), $signed(got.res_den));
                  fail_count = fail_count + 1;
               end
               if (got.cmp !== want.cmp) begin
                  $error("cmp: expected %0d, actual %0d", want.cmp, got.cmp);
                  fail_count = fail_count + 1;
               end
               if (got.err !== want.err) begin
                  $error("err: expected %0d, actual %0d", want.err, got.err);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(compute_fraction_result(req_tdata[130:0]));
            req_count <= req_count + 1;
         end
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      frac_req_type r;
      int           k;

      // Directed operations and corner cases.
      add_op(OP_MUL, 3, 4, -5, 7);
      add_op(OP_DIV, 3, 4, -5, 7);
      add_op(OP_ADD, 1, 3, 2, 5);
      add_op(OP_SUB, 1, 3, 2, 5);
      add_op(OP_INC, -7, 3, 0, 0);
      add_op(OP_DEC, 7, -3, 9, 9);
      add_op(OP_CMP, 1, 2, 2, 4);
      add_op(OP_CMP, 2, 3, 1, 2);
      add_op(OP_CMP, -1, 2, 1, -3);
      add_op(OP_UNUSED, 5, 6, 7, 8);
      add_op(OP_MUL, 5, 0, 1, 1);
      add_op(OP_INC, 5, 0, 1, 1);
      add_op(OP_ADD, 5, 1, 1, 0);
      add_op(OP_DIV, 5, 2, 0, 3);
      add_op(OP_ADD, 4, -6, 1, 6);
      add_op(OP_SUB, 4, 6, 1, 6);
      add_op(OP_MUL, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
      add_op(OP_DIV, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS);
      add_op(OP_ADD, MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS);
      add_op(OP_SUB, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS);
      add_op(OP_CMP, MOST_NEG, MOST_POS, MOST_NEG, MOST_NEG);
      add_op(OP_INC, MOST_POS, MOST_NEG, 0, 0);
      add_op(OP_DEC, MOST_NEG, 1, 0, 0);
      add_op(OP_CMP, 0, 5, 0, -7);
      add_op(OP_MUL, 0, -1, -1, -1);

      // Random operations, with equal and zero denominators mixed in.
      for (k = 0; k < RANDOM_OPS; k++) begin
         r.op    = ($urandom_range(0, 14) == 14) ? OP_UNUSED : 3'($urandom_range(0, 6));
         r.a_num = pick_operand();
         r.a_den = pick_operand();
         r.b_num = pick_operand();
         r.b_den = pick_operand();
         case ($urandom_range(0, 19))
            0, 1, 2, 3: r.b_den = r.a_den;
            4:          r.b_den = -r.a_den;
            5, 6: begin
               r.b_num = r.a_num;
               r.b_den = r.a_den;
            end
            7:          r.a_den = '0;
            8:          r.b_den = '0;
            9:          r.b_num = '0;
            default: ;
         endcase
         pending_ops.push_back(r);
      end
      total_ops = pending_ops.size();

      // Hold reset, then release it away from the sampling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (req_count == total_ops);
      wait (rsp_count == total_ops);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && awaited_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
